/* hdl/euler_to_quaternion_unit_assert.svh */
// Assertion macros for the Euler angle to quaternion unit.
`ifndef EULER_TO_QUATERNION_UNIT_ASSERT_SVH
`define EULER_TO_QUATERNION_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define E2Q_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define E2Q_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define E2Q_ASSERT(label, clk, rst_n, prop, msg)
`define E2Q_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

/* hdl/e2q_pkg.sv */
// ----------------------------------------------------------------------------
// e2q_pkg
// Types, constants and the arctangent table shared by the quaternion unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package e2q_pkg;
  localparam int unsigned CordicSteps = 30;
  localparam int unsigned AccW = 36;
  localparam int unsigned TrigW = 22;
  localparam logic signed [AccW-1:0] PiQ30 = 36'sd3373259426;
  localparam logic signed [AccW-1:0] HalfPiQ30 = 36'sd1686629713;
  localparam logic signed [AccW-1:0] GainQ30 = 36'sh026DD3B6A;

  typedef logic signed [AccW-1:0] acc_t;
  typedef logic signed [TrigW-1:0] trig_t;

  typedef struct packed {
    acc_t x;
    acc_t y;
    acc_t z;
  } rot_t;

  typedef struct packed {
    rot_t roll;
    rot_t pitch;
    rot_t yaw;
    logic flip_r;
    logic flip_p;
    logic flip_y;
  } cell_data_t;

  function automatic acc_t atan_q30(input int unsigned i);
    acc_t r;
    case (i)
      0: r = 36'sh03243F6A8;
      1: r = 36'sh01DAC6705;
      2: r = 36'sh00FADBAFC;
      3: r = 36'sh007F56EA6;
      4: r = 36'sh003FEAB76;
      5: r = 36'sh001FFD55B;
      6: r = 36'sh000FFFAAA;
      7: r = 36'sh0007FFF55;
      8: r = 36'sh0003FFFEA;
      9: r = 36'sh0001FFFFD;
      10: r = 36'sh0000FFFFF;
      11: r = 36'sh00007FFFF;
      12: r = 36'sh00003FFFF;
      13: r = 36'sh00001FFFF;
      14: r = 36'sh00000FFFF;
      15: r = 36'sh000007FFF;
      16: r = 36'sh000003FFF;
      17: r = 36'sh000001FFF;
      18: r = 36'sh000000FFF;
      19: r = 36'sh0000007FF;
      20: r = 36'sh0000003FF;
      21: r = 36'sh0000001FF;
      22: r = 36'sh0000000FF;
      23: r = 36'sh00000007F;
      24: r = 36'sh00000003F;
      25: r = 36'sh00000001F;
      26: r = 36'sh00000000F;
      27: r = 36'sh000000008;
      28: r = 36'sh000000004;
      29: r = 36'sh000000002;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic rot_t rot_step(input rot_t a, input int unsigned i);
    rot_t r;
    acc_t dx;
    acc_t dy;
    dx = a.y >>> i;
    dy = a.x >>> i;
    if (!a.z[AccW-1]) begin
      r.x = a.x - dx;
      r.y = a.y + dy;
      r.z = a.z - atan_q30(i);
    end else begin
      r.x = a.x + dx;
      r.y = a.y - dy;
      r.z = a.z + atan_q30(i);
    end
    return r;
  endfunction
endpackage

/* hdl/e2q_cell.sv */
// ----------------------------------------------------------------------------
// e2q_cell
// One CORDIC rotation of all three angles, registered, with its valid bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module e2q_cell
  import e2q_pkg::*;
#(
  parameter int unsigned STEP = 0
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       valid_i,
  input  cell_data_t data_i,
  output logic       valid_o,
  output cell_data_t data_o
);
  logic valid_q;
  cell_data_t data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q.roll   <= rot_step(data_i.roll, STEP);
      data_q.pitch  <= rot_step(data_i.pitch, STEP);
      data_q.yaw    <= rot_step(data_i.yaw, STEP);
      data_q.flip_r <= data_i.flip_r;
      data_q.flip_p <= data_i.flip_p;
      data_q.flip_y <= data_i.flip_y;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule

/* hdl/e2q_combine.sv */
// ----------------------------------------------------------------------------
// e2q_combine
// Rounds the sines and cosines and forms the quaternion over three stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module e2q_combine
  import e2q_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  cell_data_t        data_i,
  output logic              valid_o,
  output logic signed [15:0] quat_w_o,
  output logic signed [15:0] quat_x_o,
  output logic signed [15:0] quat_y_o,
  output logic signed [15:0] quat_z_o
);
  `include "euler_to_quaternion_unit_assert.svh"

  logic [2:0] valid_q;
  trig_t sr_q, cr_q, sp_q, cp_q, sy_q, cy_q;
  logic signed [2*TrigW-1:0] cpcy_q, spsy_q, cpsy_q, spcy_q;
  trig_t sr2_q, cr2_q;
  logic signed [63:0] p_cr_cpcy, p_sr_spsy, p_sr_cpcy, p_cr_spsy;
  logic signed [63:0] p_cr_spcy, p_sr_cpsy, p_cr_cpsy, p_sr_spcy;
  logic signed [63:0] w_d, x_d, y_d, z_d;
  logic signed [15:0] w_q, x_q, y_q, z_q;

  function automatic trig_t round_trig(input acc_t v, input logic flip);
    acc_t t;
    acc_t s;
    t = flip ? -v : v;
    s = (t + acc_t'(512)) >>> 10;
    return s[TrigW-1:0];
  endfunction

  function automatic logic signed [15:0] to_q14(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = (v + (64'sd1 <<< 45)) >>> 46;
    if (r > 64'sd16384) r = 64'sd16384;
    if (r < -64'sd16384) r = -64'sd16384;
    return r[15:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cr_q <= round_trig(data_i.roll.x, data_i.flip_r);
      sr_q <= round_trig(data_i.roll.y, data_i.flip_r);
      cp_q <= round_trig(data_i.pitch.x, data_i.flip_p);
      sp_q <= round_trig(data_i.pitch.y, data_i.flip_p);
      cy_q <= round_trig(data_i.yaw.x, data_i.flip_y);
      sy_q <= round_trig(data_i.yaw.y, data_i.flip_y);
      cpcy_q <= cp_q * cy_q;
      spsy_q <= sp_q * sy_q;
      cpsy_q <= cp_q * sy_q;
      spcy_q <= sp_q * cy_q;
      sr2_q <= sr_q;
      cr2_q <= cr_q;
      w_q <= to_q14(w_d);
      x_q <= to_q14(x_d);
      y_q <= to_q14(y_d);
      z_q <= to_q14(z_d);
    end
  end

  always_comb begin
    p_cr_cpcy = cr2_q * cpcy_q;
    p_sr_spsy = sr2_q * spsy_q;
    p_sr_cpcy = sr2_q * cpcy_q;
    p_cr_spsy = cr2_q * spsy_q;
    p_cr_spcy = cr2_q * spcy_q;
    p_sr_cpsy = sr2_q * cpsy_q;
    p_cr_cpsy = cr2_q * cpsy_q;
    p_sr_spcy = sr2_q * spcy_q;
    w_d = p_cr_cpcy + p_sr_spsy;
    x_d = p_sr_cpcy - p_cr_spsy;
    y_d = p_cr_spcy + p_sr_cpsy;
    z_d = p_cr_cpsy - p_sr_spcy;
  end

  assign valid_o  = valid_q[2];
  assign quat_w_o = w_q;
  assign quat_x_o = x_q;
  assign quat_y_o = y_q;
  assign quat_z_o = z_q;

  `E2Q_ASSERT(a_w_range, clk_i, rst_ni, valid_o |-> (quat_w_o <= 16'sd16384 && quat_w_o >= -16'sd16384), "w out of range")
  `E2Q_ASSERT(a_valid_shift, clk_i, rst_ni, en_i |=> valid_q[1] == $past(valid_q[0]), "combine valid lost")
  `E2Q_ASSERT(a_hold, clk_i, rst_ni, !en_i |=> $stable(w_q) && $stable(valid_q), "stalled stage moved")
endmodule

/* hdl/euler_to_quaternion_unit.sv */
// Throughput: one item every cycle unless the result is stalled, through an
// input register, a chain of 30 CORDIC cells of one rotation each, and a rounding, a product and a sum stage.
// The whole pipeline advances together, held while the result is stalled.
// Reset clears all valid bits asynchronously; data registers are not reset.
// ----------------------------------------------------------------------------
// euler_to_quaternion_unit
// Converts roll, pitch and yaw angles to a ZYX attitude quaternion.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module euler_to_quaternion_unit
  import e2q_pkg::*;
#(
  parameter int unsigned ANGLE_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [ANGLE_BITS-1:0] roll_angle_i,
  input  logic signed [ANGLE_BITS-1:0] pitch_angle_i,
  input  logic signed [ANGLE_BITS-1:0] yaw_angle_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [15:0]           quat_w_o,
  output logic signed [15:0]           quat_x_o,
  output logic signed [15:0]           quat_y_o,
  output logic signed [15:0]           quat_z_o
);
  `include "euler_to_quaternion_unit_assert.svh"

  logic en;
  logic in_valid_q;
  cell_data_t in_q;
  logic [CordicSteps:0] v;
  cell_data_t d [CordicSteps+1];

  assign en = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  function automatic acc_t half_angle(input logic signed [ANGLE_BITS-1:0] a);
    acc_t t;
    t = acc_t'(a);
    return t <<< (32 - ANGLE_BITS);
  endfunction

  function automatic logic pre_flip(input logic signed [ANGLE_BITS-1:0] a);
    acc_t z;
    z = half_angle(a);
    return (z > HalfPiQ30) || (z < -HalfPiQ30);
  endfunction

  function automatic rot_t pre(input logic signed [ANGLE_BITS-1:0] a);
    rot_t r;
    acc_t z;
    z = half_angle(a);
    if (z > HalfPiQ30) begin
      z = z - PiQ30;
    end else if (z < -HalfPiQ30) begin
      z = z + PiQ30;
    end
    r.x = GainQ30;
    r.y = '0;
    r.z = z;
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (en) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_q.roll   <= pre(roll_angle_i);
      in_q.pitch  <= pre(pitch_angle_i);
      in_q.yaw    <= pre(yaw_angle_i);
      in_q.flip_r <= pre_flip(roll_angle_i);
      in_q.flip_p <= pre_flip(pitch_angle_i);
      in_q.flip_y <= pre_flip(yaw_angle_i);
    end
  end

  assign v[0] = in_valid_q;
  assign d[0] = in_q;

  for (genvar i = 0; i < CordicSteps; i++) begin : g_cell
    e2q_cell #(.STEP(i)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (v[i]),
      .data_i  (d[i]),
      .valid_o (v[i+1]),
      .data_o  (d[i+1])
    );
  end

  e2q_combine u_combine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (v[CordicSteps]),
    .data_i   (d[CordicSteps]),
    .valid_o  (out_valid_o),
    .quat_w_o (quat_w_o),
    .quat_x_o (quat_x_o),
    .quat_y_o (quat_y_o),
    .quat_z_o (quat_z_o)
  );

  `E2Q_ASSERT(a_stall_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(quat_w_o), "stalled item changed")
  `E2Q_ASSERT(a_in_stall, clk_i, rst_ni, in_stall_o |-> out_valid_o, "input stalled without waiting item")
  `E2Q_ASSERT_RST(a_reset_clear, clk_i, !rst_ni |=> !out_valid_o, "valid during reset")
endmodule
